@@ sv/rmfb_pkg.sv @@
// Shared sizes, command codes and the plot request type of the rotated frame store.
package rmfb_pkg;

	localparam int PANEL_WIDTH  = 400;
	localparam int PANEL_HEIGHT = 300;
	localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
	localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;
	localparam int ADDR_W       = $clog2(STORE_BYTES);
	localparam int MAX_DIM      = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
	localparam int COORD_W      = $clog2(MAX_DIM);

	localparam logic [7:0] BYTE_WHITE = 8'hFF;
	localparam logic [7:0] BYTE_BLACK = 8'h00;

	typedef enum logic [1:0] {
		CMD_PLOT = 2'd0,
		CMD_FILL = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef logic [ADDR_W-1:0] addr_t;

	// Resolved plot: byte address and bit mask, ok low when off the panel.
	typedef struct packed {
		logic       ok;
		addr_t      addr;
		logic [7:0] mask;
	} plot_req_t;

endpackage

@@ sv/rmfb_ram.sv @@
// Byte-wide frame memory, one write port and one read port with registered read data.
module rmfb_ram
	import rmfb_pkg::*;
(
	input  logic       clk,
	input  logic       we,
	input  addr_t      waddr,
	input  logic [7:0] wdata,
	input  addr_t      raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [STORE_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ sv/rmfb_addr.sv @@
// Plot address unit: bounds check, quarter-turn rotation, x mirror, byte address and mask.
module rmfb_addr
	import rmfb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [1:0]         rotation,
	input  logic signed [15:0] pixel_x,
	input  logic signed [15:0] pixel_y,
	output plot_req_t          req_s1
);

	localparam logic [15:0]        DIM_W  = 16'(PANEL_WIDTH);
	localparam logic [15:0]        DIM_H  = 16'(PANEL_HEIGHT);
	localparam logic [COORD_W-1:0] W_M1   = COORD_W'(PANEL_WIDTH - 1);
	localparam logic [COORD_W-1:0] H_M1   = COORD_W'(PANEL_HEIGHT - 1);
	localparam addr_t              ROW_B  = ADDR_W'(ROW_BYTES);

	logic [15:0]        lw, lh;
	logic               in_bounds;
	logic [COORD_W-1:0] xc, yc, px, py, pxm;
	addr_t              idx;

	always_comb begin
		lw = rotation[0] ? DIM_H : DIM_W;
		lh = rotation[0] ? DIM_W : DIM_H;
		in_bounds = !pixel_x[15] && !pixel_y[15]
			&& ($unsigned(pixel_x) < lw) && ($unsigned(pixel_y) < lh);
		xc = pixel_x[COORD_W-1:0];
		yc = pixel_y[COORD_W-1:0];
		unique case (rotation)
			2'd1: begin
				px = yc;
				py = H_M1 - xc;
			end
			2'd2: begin
				px = W_M1 - xc;
				py = H_M1 - yc;
			end
			2'd3: begin
				px = W_M1 - yc;
				py = xc;
			end
			default: begin
				px = xc;
				py = yc;
			end
		endcase
		pxm = W_M1 - px;
		idx = ADDR_W'(pxm >> 3) + ADDR_W'(py) * ROW_B;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1.ok   <= 1'b0;
			req_s1.addr <= '0;
			req_s1.mask <= '0;
		end else if (load) begin
			req_s1.ok   <= in_bounds;
			req_s1.addr <= idx;
			req_s1.mask <= 8'h80 >> pxm[2:0];
		end
	end

endmodule

@@ sv/rotated_mono_framebuffer_unit.sv @@
// Top level of the rotated one-bit-per-pixel frame store with plot, fill and read requests.
//
// One request is in work at a time. A plot goes through the address unit, the memory
// read and the write back, and ends after the read when it falls off the logical
// area; a read leaves its result in an output register, so a following plot or fill
// is taken while it waits; a fill sweeps every byte, one byte a cycle through the
// single memory write port. After reset the same sweep writes every byte white, and
// during it no request is accepted; rotation writes are taken at any time. Plots off
// the logical area and unused command codes are dropped; a read past the end returns
// 0xFF.
module rotated_mono_framebuffer_unit
	import rmfb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] pixel_x,
	input  logic signed [15:0] pixel_y,
	input  logic               ink_white,
	input  logic [13:0]        byte_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         read_data,
	input  logic               rotation_we,
	input  logic [1:0]         rotation_wdata
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PLOT_RD,
		ST_PLOT_WR,
		ST_FILL,
		ST_READ
	} state_t;

	localparam addr_t LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	state_t     state_q;
	logic [1:0] rotation_q;
	addr_t      sweep_q;
	logic [7:0] fill_q;
	logic       ink_q;
	logic       past_end_q;
	logic       out_valid_q;
	logic [7:0] out_data_q;

	logic       accept;
	cmd_t       cmd_c;
	plot_req_t  req_s1;

	logic       ram_we;
	addr_t      ram_waddr;
	logic [7:0] ram_wdata;
	addr_t      ram_raddr;
	logic [7:0] ram_rdata;

	assign cmd_c = cmd_t'(cmd);

	// A read request needs the output slot, free now or freed at this edge.
	assign in_ready = (state_q == ST_IDLE)
		&& (cmd_c != CMD_READ || !out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign read_data = out_data_q;

	rmfb_addr u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && cmd_c == CMD_PLOT),
		.rotation (rotation_q),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.req_s1   (req_s1)
	);

	// Write port: sweep during clear/fill, read-modify-write for a plot.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = fill_q;
		unique case (state_q)
			ST_CLEAR, ST_FILL: begin
				ram_we = 1'b1;
			end
			ST_PLOT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = req_s1.addr;
				ram_wdata = ink_q ? (ram_rdata | req_s1.mask)
					: (ram_rdata & ~req_s1.mask);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		// Read address: the plot target while resolving it, else the requested byte.
		ram_raddr = (state_q == ST_PLOT_RD) ? req_s1.addr : ADDR_W'(byte_index);
	end

	rmfb_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rotation_q  <= 2'd0;
			sweep_q     <= '0;
			fill_q      <= BYTE_WHITE;
			out_valid_q <= 1'b0;
		end else begin
			if (rotation_we) begin
				rotation_q <= rotation_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR, ST_FILL: begin
					if (sweep_q == LAST_ADDR) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + addr_t'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd_c)
							CMD_PLOT: state_q <= ST_PLOT_RD;
							CMD_FILL: begin
								fill_q  <= ink_white ? BYTE_WHITE : BYTE_BLACK;
								sweep_q <= '0;
								state_q <= ST_FILL;
							end
							CMD_READ: state_q <= ST_READ;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_PLOT_RD: begin
					// Off-panel plots end here without touching memory.
					state_q <= req_s1.ok ? ST_PLOT_WR : ST_IDLE;
				end
				ST_PLOT_WR: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: ink of a plot, past-end flag of a read, result byte.
	always_ff @(posedge clk) begin
		if (accept) begin
			ink_q      <= ink_white;
			past_end_q <= !(32'(byte_index) < 32'(STORE_BYTES));
		end
		if (state_q == ST_READ) begin
			out_data_q <= past_end_q ? BYTE_WHITE : ram_rdata;
		end
	end

endmodule
